@@ src/trial_division_prime_test_top_defines.svh @@
// Assertion macros shared by the trial-division prime tester RTL.
`ifndef TRIAL_DIVISION_PRIME_TEST_TOP_DEFINES_SVH
`define TRIAL_DIVISION_PRIME_TEST_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TDPT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tdpt assertion failed");

// Next-cycle implication, disabled during reset.
`define TDPT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tdpt assertion failed");

`endif

@@ src/tdpt_pkg.sv @@
// Shared constants and types for the trial-division prime tester.
`default_nettype none

package tdpt_pkg;

    localparam int DEFAULT_VALUE_WIDTH = 64;
    localparam int FIRST_DIVISOR       = 3;
    localparam int FIRST_SQUARE        = 9;
    localparam int DIVISOR_STEP        = 2;
    localparam int SQUARE_STEP_CONST   = 4;

    // Status of the remainder unit as seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic zero;
    } rem_status_t;

endpackage

`default_nettype wire

@@ src/tdpt_rem_unit.sv @@
// Shared restoring remainder unit: dividend mod divisor, one bit per cycle.
`default_nettype none

module tdpt_rem_unit #(
    parameter int VALUE_WIDTH = tdpt_pkg::DEFAULT_VALUE_WIDTH,
    parameter int DIV_WIDTH   = (tdpt_pkg::DEFAULT_VALUE_WIDTH + 1) / 2 + 2
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [VALUE_WIDTH-1:0] dividend,
    input  wire logic [DIV_WIDTH-1:0]   divisor,
    output tdpt_pkg::rem_status_t       status
);
    import tdpt_pkg::*;

    localparam int CNT_WIDTH = $clog2(VALUE_WIDTH + 1);

    logic                   busy_reg, busy_next;
    logic [CNT_WIDTH-1:0]   cnt_reg, cnt_next;
    logic [DIV_WIDTH-1:0]   rem_reg, rem_next;
    logic [VALUE_WIDTH-1:0] shift_reg, shift_next;
    logic [DIV_WIDTH:0]     trial;

    always_comb
    begin
        busy_next  = busy_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        shift_next = shift_reg;
        trial      = {rem_reg, shift_reg[VALUE_WIDTH-1]};
        if (start)
        begin
            busy_next  = 1'b1;
            cnt_next   = CNT_WIDTH'(VALUE_WIDTH);
            rem_next   = '0;
            shift_next = dividend;
        end
        else if (busy_reg)
        begin
            // rem < divisor, so trial < 2*divisor and one subtract restores it
            if (trial >= {1'b0, divisor})
                rem_next = DIV_WIDTH'(trial - {1'b0, divisor});
            else
                rem_next = DIV_WIDTH'(trial);
            shift_next = shift_reg << 1;
            cnt_next   = cnt_reg - CNT_WIDTH'(1);
            busy_next  = (cnt_reg != CNT_WIDTH'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else
            busy_reg <= busy_next;
    end

    always_ff @(posedge clk)
    begin
        cnt_reg   <= cnt_next;
        rem_reg   <= rem_next;
        shift_reg <= shift_next;
    end

    assign status.busy = busy_reg;
    assign status.zero = (rem_reg == '0);

endmodule

`default_nettype wire

@@ src/trial_division_prime_test_top.sv @@
// Top level of the trial-division prime tester: sequencer and output register.
// Flow: 0, 1 and even values go from ST_IDLE straight to ST_FINISH, which loads out.
// Odd values: each odd candidate tried takes a bound check (ST_BOUND), then a remainder (ST_DIVIDE),
// up to about sqrt(value)/2 candidates; a prime ends with a final bound check, then ST_FINISH loads out.
// Rate is set by the shared remainder unit, which retires one dividend bit a cycle.
// Throughput: one request at a time; in_stall is high until the verdict reaches the output reg.
// Reset: asynchronous, active low; sequencer idles and the output register empties.
`default_nettype none

`include "trial_division_prime_test_top_defines.svh"

module trial_division_prime_test_top #(
    parameter int VALUE_WIDTH = tdpt_pkg::DEFAULT_VALUE_WIDTH
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // request channel
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [VALUE_WIDTH-1:0] value,
    // result channel
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic                        is_prime
);
    import tdpt_pkg::*;

    // Candidate n tops out just above sqrt(2^W); its square fits in W+2 bits.
    localparam int DIV_WIDTH = (VALUE_WIDTH + 1) / 2 + 2;
    localparam int SQ_WIDTH  = VALUE_WIDTH + 2;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_BOUND  = 4'b0010,
        ST_DIVIDE = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    logic [VALUE_WIDTH-1:0] value_reg, value_next;
    logic [DIV_WIDTH-1:0]   n_reg, n_next;        // odd candidate divisor
    logic [SQ_WIDTH-1:0]    sq_reg, sq_next;      // n * n, kept incrementally
    logic                   result_reg, result_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   is_prime_reg, is_prime_next;
    logic                   div_start;
    rem_status_t            rem_status;

    tdpt_rem_unit #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .DIV_WIDTH   (DIV_WIDTH)
    ) u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (value_reg),
        .divisor  (n_reg),
        .status   (rem_status)
    );

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        value_next     = value_reg;
        n_next         = n_reg;
        sq_next        = sq_reg;
        result_next    = result_reg;
        is_prime_next  = is_prime_reg;
        out_valid_next = out_valid_reg && out_stall;
        div_start      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    value_next = value;
                    n_next     = DIV_WIDTH'(FIRST_DIVISOR);
                    sq_next    = SQ_WIDTH'(FIRST_SQUARE);
                    // zero and one are not prime, two is, other evens are not
                    if (value[VALUE_WIDTH-1:1] == '0)
                    begin
                        result_next = 1'b0;
                        state_next  = ST_FINISH;
                    end
                    else if (value == VALUE_WIDTH'(2))
                    begin
                        result_next = 1'b1;
                        state_next  = ST_FINISH;
                    end
                    else if (!value[0])
                    begin
                        result_next = 1'b0;
                        state_next  = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_BOUND;
                    end
                end
            end
            ST_BOUND:
            begin
                // n*n above value: no divisor left, value is prime
                if (sq_reg > {2'b00, value_reg})
                begin
                    result_next = 1'b1;
                    state_next  = ST_FINISH;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (!rem_status.busy)
                begin
                    if (rem_status.zero)
                    begin
                        result_next = 1'b0;
                        state_next  = ST_FINISH;
                    end
                    else
                    begin
                        // (n+2)^2 = n^2 + 4n + 4
                        sq_next = sq_reg + SQ_WIDTH'({n_reg, 2'b00})
                                + SQ_WIDTH'(SQUARE_STEP_CONST);
                        n_next     = n_reg + DIV_WIDTH'(DIVISOR_STEP);
                        state_next = ST_BOUND;
                    end
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    is_prime_next  = result_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg    <= value_next;
        n_reg        <= n_next;
        sq_reg       <= sq_next;
        result_reg   <= result_next;
        is_prime_reg <= is_prime_next;
    end

    assign out_valid = out_valid_reg;
    assign is_prime  = is_prime_reg;

    // Launching a division always leaves the remainder unit busy next cycle.
    `TDPT_ASSERT_NEXT(a_start_busy, div_start, rem_status.busy)
    // An accepted request occupies the sequencer.
    `TDPT_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, in_stall)
    // Handing off from FINISH always fills the output register.
    `TDPT_ASSERT_NEXT(a_finish_load,
        state_reg == ST_FINISH && (!out_valid_reg || !out_stall), out_valid)
    // Only odd candidates are ever divided by.
    `TDPT_ASSERT_NOW(a_divisor_odd, state_reg == ST_DIVIDE, n_reg[0])

endmodule

`default_nettype wire
